>>> design/keyed_compacting_entry_list_core_macros.svh
`ifndef KEYED_COMPACTING_ENTRY_LIST_CORE_MACROS_SVH
`define KEYED_COMPACTING_ENTRY_LIST_CORE_MACROS_SVH

// same-cycle implication, clocked by i_clk, off during reset
`define KCEL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked by i_clk, off during reset
`define KCEL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/kcel_pkg.sv
package kcel_pkg;

    typedef struct packed {
        logic [15:0] pidx;
        logic [7:0]  member;
        logic [7:0]  block;
        logic [7:0]  node;
    } t_entry;

    typedef logic [2:0] t_cmd;
    localparam t_cmd CMD_APPEND   = 3'd0;
    localparam t_cmd CMD_FIND     = 3'd1;
    localparam t_cmd CMD_REM_KEY  = 3'd2;
    localparam t_cmd CMD_REM_NODE = 3'd3;
    localparam t_cmd CMD_SHIFT    = 3'd4;
    localparam t_cmd CMD_READ     = 3'd5;
    localparam t_cmd CMD_COUNT    = 3'd6;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;
    localparam t_status ST_MISS  = 2'd3;

    typedef logic [2:0] t_cell_op;
    localparam t_cell_op CELL_HOLD      = 3'd0;
    localparam t_cell_op CELL_LOAD      = 3'd1;
    localparam t_cell_op CELL_MARK_KEY  = 3'd2;
    localparam t_cell_op CELL_MARK_NODE = 3'd3;
    localparam t_cell_op CELL_SCAN      = 3'd4;
    localparam t_cell_op CELL_DROP      = 3'd5;
    localparam t_cell_op CELL_SHIFT     = 3'd6;
    localparam t_cell_op CELL_ROTATE    = 3'd7;

    typedef struct packed {
        t_cell_op    op;
        t_entry      entry;
        logic [15:0] ref_idx;
        logic [7:0]  shift_amt;
    } t_cell_ctl;

endpackage

>>> design/kcel_cell.sv
module kcel_cell #(
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic               i_clk,
    input  kcel_pkg::t_cell_ctl i_ctl,
    input  logic [CNT_W-1:0]   i_cnt,
    input  logic [CNT_W-1:0]   i_pos,
    input  kcel_pkg::t_entry   i_next_entry,
    input  logic               i_next_flag,
    output kcel_pkg::t_entry   o_entry,
    output logic               o_flag
);
    import kcel_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

    t_entry r_entry, n_entry;
    logic   r_flag, n_flag;
    logic   in_list;

    assign in_list = (MY_IDX < i_cnt);

    always_comb begin
        n_entry = r_entry;
        n_flag  = r_flag;
        case (i_ctl.op)
            CELL_LOAD: begin
                if (MY_IDX == i_cnt) begin
                    n_entry = i_ctl.entry;
                end
            end
            CELL_MARK_KEY: begin
                n_flag = in_list && (r_entry.node == i_ctl.entry.node)
                         && (r_entry.block == i_ctl.entry.block)
                         && (r_entry.member == i_ctl.entry.member);
            end
            CELL_MARK_NODE: begin
                n_flag = in_list && (r_entry.node == i_ctl.entry.node);
            end
            CELL_SCAN: begin
                n_flag = i_next_flag;
            end
            CELL_DROP: begin
                n_flag = i_next_flag;
                if (MY_IDX >= i_pos) begin
                    n_entry = i_next_entry;
                end
            end
            CELL_SHIFT: begin
                if (in_list && (r_entry.pidx >= i_ctl.ref_idx)) begin
                    n_entry.pidx = r_entry.pidx + {{8{i_ctl.shift_amt[7]}}, i_ctl.shift_amt};
                end
            end
            CELL_ROTATE: begin
                n_entry = i_next_entry;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_flag  <= n_flag;
    end

    assign o_entry = r_entry;
    assign o_flag  = r_flag;

endmodule

>>> design/kcel_ctrl.sv
`include "keyed_compacting_entry_list_core_macros.svh"

module kcel_ctrl #(
    parameter int LIST_DEPTH = 64,
    parameter int CNT_W      = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [6:0]           i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  kcel_pkg::t_cmd       i_cmd,
    input  kcel_pkg::t_entry     i_key,
    input  logic [15:0]          i_ref_idx,
    input  logic [7:0]           i_shift_amt,
    input  logic [7:0]           i_pos,
    output logic                 o_valid,
    input  logic                 i_ready,
    output kcel_pkg::t_status    o_status,
    output logic [5:0]           o_slot,
    output kcel_pkg::t_entry     o_entry,
    output logic [6:0]           o_count,
    output kcel_pkg::t_cell_ctl  o_ctl,
    output logic [CNT_W-1:0]     o_cnt,
    output logic [CNT_W-1:0]     o_pos,
    input  kcel_pkg::t_entry     i_head_entry,
    input  logic                 i_head_flag
);
    import kcel_pkg::*;

    localparam int MW = (CNT_W > 7) ? CNT_W : 7;
    localparam int SW = (CNT_W > 6) ? CNT_W : 6;
    localparam int PW = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);
    localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(LIST_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_ROT  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [6:0]       r_cap, n_cap;
    logic [CNT_W-1:0] r_p, n_p;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_lim, n_lim;
    logic [CNT_W-1:0] r_rpos, n_rpos;
    t_cmd             r_mode, n_mode;
    t_status          r_status, n_status;
    logic [CNT_W-1:0] r_slot, n_slot;
    t_entry           r_rd, n_rd;
    logic             r_ovalid, n_ovalid;
    t_status          r_o_status, n_o_status;
    logic [5:0]       r_o_slot, n_o_slot;
    t_entry           r_o_entry, n_o_entry;
    logic [6:0]       r_o_count, n_o_count;

    logic             accept;
    logic             full;
    logic [PW-1:0]    pos_ext;
    logic [PW-1:0]    cnt_ext;
    logic [MW-1:0]    cnt_m;
    logic [SW-1:0]    slot_ext;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign pos_ext  = PW'(i_pos);
    assign cnt_ext  = PW'(r_cnt);
    assign cnt_m    = MW'(r_cnt);
    assign full     = (r_cnt >= DEPTH_CNT) || (cnt_m >= MW'(r_cap));
    assign slot_ext = SW'(r_slot);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_cap      = r_cap;
        n_p        = r_p;
        n_j        = r_j;
        n_lim      = r_lim;
        n_rpos     = r_rpos;
        n_mode     = r_mode;
        n_status   = r_status;
        n_slot     = r_slot;
        n_rd       = r_rd;
        n_ovalid   = r_ovalid;
        n_o_status = r_o_status;
        n_o_slot   = r_o_slot;
        n_o_entry  = r_o_entry;
        n_o_count  = r_o_count;

        o_ctl.op        = CELL_HOLD;
        o_ctl.entry     = i_key;
        o_ctl.ref_idx   = i_ref_idx;
        o_ctl.shift_amt = i_shift_amt;

        if (i_cfg_wr_en) begin
            n_cap = i_cfg_wr_data;
        end
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_slot   = '0;
                    n_rd     = '0;
                    n_mode   = i_cmd;
                    n_p      = '0;
                    n_j      = '0;
                    n_lim    = r_cnt;
                    n_rpos   = pos_ext[CNT_W-1:0];
                    n_state  = S_FIN;
                    case (i_cmd)
                        CMD_APPEND: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_ctl.op = CELL_LOAD;
                                n_cnt    = r_cnt + CNT_ONE;
                            end
                        end
                        CMD_FIND, CMD_REM_KEY: begin
                            o_ctl.op = CELL_MARK_KEY;
                            n_state  = S_SCAN;
                        end
                        CMD_REM_NODE: begin
                            o_ctl.op = CELL_MARK_NODE;
                            n_state  = S_SCAN;
                        end
                        CMD_SHIFT: begin
                            o_ctl.op = CELL_SHIFT;
                        end
                        CMD_READ: begin
                            if (pos_ext >= cnt_ext) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_state = S_ROT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_j == r_lim) begin
                    if (r_mode != CMD_REM_NODE) begin
                        n_status = ST_MISS;
                    end
                    n_state = S_FIN;
                end else if (i_head_flag) begin
                    if (r_mode == CMD_REM_NODE) begin
                        o_ctl.op = CELL_DROP;
                        n_cnt    = r_cnt - CNT_ONE;
                        n_j      = r_j + CNT_ONE;
                    end else begin
                        n_slot  = r_p;
                        n_state = S_FIN;
                        if (r_mode == CMD_REM_KEY) begin
                            o_ctl.op = CELL_DROP;
                            n_cnt    = r_cnt - CNT_ONE;
                        end
                    end
                end else begin
                    o_ctl.op = CELL_SCAN;
                    n_p      = r_p + CNT_ONE;
                    n_j      = r_j + CNT_ONE;
                end
            end
            S_ROT: begin
                o_ctl.op = CELL_ROTATE;
                if (r_j == r_rpos) begin
                    n_rd = i_head_entry;
                end
                n_j = r_j + CNT_ONE;
                if (r_j == LAST_IDX) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_slot   = slot_ext[5:0];
                    n_o_entry  = r_rd;
                    n_o_count  = cnt_m[6:0];
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_cap    <= 7'd64;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_cap    <= n_cap;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_j        <= n_j;
        r_lim      <= n_lim;
        r_rpos     <= n_rpos;
        r_mode     <= n_mode;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_rd       <= n_rd;
        r_o_status <= n_o_status;
        r_o_slot   <= n_o_slot;
        r_o_entry  <= n_o_entry;
        r_o_count  <= n_o_count;
    end

    assign o_valid  = r_ovalid;
    assign o_status = r_o_status;
    assign o_slot   = r_o_slot;
    assign o_entry  = r_o_entry;
    assign o_count  = r_o_count;
    assign o_cnt    = r_cnt;
    assign o_pos    = r_p;

    `KCEL_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= DEPTH_CNT, "entry count above depth")
    `KCEL_ASSERT_IMP(a_scan_ptr, r_state == S_SCAN, (r_p <= r_j) && (r_j <= r_lim), "scan pointers out of order")
    `KCEL_ASSERT_NXT(a_append_grow, accept && (i_cmd == CMD_APPEND) && !full, r_cnt == $past(r_cnt) + CNT_ONE, "append did not grow list")
    `KCEL_ASSERT_IMP(a_rot_bound, r_state == S_ROT, r_j <= LAST_IDX, "rotation past depth")

endmodule

>>> design/keyed_compacting_entry_list_core.sv
// Ordered list of (node, block, member, packet index) entries held in a row of LIST_DEPTH
// cells, kept packed from slot 0. One command is taken at a time and each gives exactly one
// result transaction. Append, shift indexes, count, the unused code, an append to a full list
// and an out-of-range read go from acceptance straight to the result state; find and remove
// key end at the first match or the list end and remove node at the list end, set by the match
// flags stepping one cell per cycle toward the head; an in-range read slot waits for one full
// rotation of the cell row past cell 0. A new command is accepted once the previous one has
// moved its result into the output register, even while that result still waits to be taken.
module keyed_compacting_entry_list_core #(
    parameter int LIST_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,   // capacity_limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // node_key, block_key, member_key, packet_index_in, reference_index, shift_amount,
    // slot_position
    input  logic [71:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,    // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // found_slot, node_out, block_out, member_out, packet_index_out, entry_count, zero pad
    output logic [55:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser     // status
);
    import kcel_pkg::*;

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    t_entry           key;
    t_cell_ctl        ctl;
    logic [CNT_W-1:0] cell_cnt;
    logic [CNT_W-1:0] cell_pos;
    t_entry           out_entry;
    t_status          out_status;
    logic [5:0]       out_slot;
    logic [6:0]       out_count;
    t_entry           cell_entry [LIST_DEPTH];
    logic             cell_flag  [LIST_DEPTH];

    assign key.node   = s_axis_tdata[7:0];
    assign key.block  = s_axis_tdata[15:8];
    assign key.member = s_axis_tdata[23:16];
    assign key.pidx   = s_axis_tdata[39:24];

    kcel_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_cmd         (s_axis_tuser),
        .i_key         (key),
        .i_ref_idx     (s_axis_tdata[55:40]),
        .i_shift_amt   (s_axis_tdata[63:56]),
        .i_pos         (s_axis_tdata[71:64]),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_status      (out_status),
        .o_slot        (out_slot),
        .o_entry       (out_entry),
        .o_count       (out_count),
        .o_ctl         (ctl),
        .o_cnt         (cell_cnt),
        .o_pos         (cell_pos),
        .i_head_entry  (cell_entry[0]),
        .i_head_flag   (cell_flag[0])
    );

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        t_entry next_entry;
        logic   next_flag;
        if (g == LIST_DEPTH - 1) begin : g_tail
            // tail wraps to the head for rotation
            assign next_entry = cell_entry[0];
            assign next_flag  = 1'b0;
        end else begin : g_body
            assign next_entry = cell_entry[g + 1];
            assign next_flag  = cell_flag[g + 1];
        end
        kcel_cell #(
            .CNT_W    (CNT_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_cnt        (cell_cnt),
            .i_pos        (cell_pos),
            .i_next_entry (next_entry),
            .i_next_flag  (next_flag),
            .o_entry      (cell_entry[g]),
            .o_flag       (cell_flag[g])
        );
    end

    assign m_axis_tuser = out_status;
    assign m_axis_tdata = {3'b000, out_count, out_entry.pidx, out_entry.member,
                           out_entry.block, out_entry.node, out_slot};

endmodule

>>> tb/kcel_list_checker.sv
`timescale 1ns / 100ps

module kcel_list_checker #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [71:0] i_cmd_data,
    input  logic [2:0]  i_cmd_kind,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [55:0] i_rsp_data,
    input  logic [1:0]  i_rsp_status,
    output int          o_err_count,
    output int          o_pending
);
    import kcel_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [5:0]  slot;
        t_entry      entry;
        logic [6:0]  count;
    } t_list_result;

    t_entry       list_mem [DEPTH];
    int           list_len;
    logic [6:0]   cap_limit;
    t_list_result result_q [$];

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (o_err_count < 40)
            $display("%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        o_err_count++;
    endtask

    function automatic t_list_result apply_command(input t_cmd cmd, input logic [71:0] d);
        t_entry       key;
        logic [15:0]  ref_idx;
        logic [15:0]  delta;
        logic [7:0]   pos;
        int           lim;
        int           wr;
        int           hit;
        t_list_result res;
        key.node   = d[7:0];
        key.block  = d[15:8];
        key.member = d[23:16];
        key.pidx   = d[39:24];
        ref_idx    = d[55:40];
        delta      = {{8{d[63]}}, d[63:56]};
        pos        = d[71:64];
        res        = '0;
        hit        = -1;
        for (int i = 0; i < list_len; i++) begin
            if (hit < 0 && list_mem[i].node == key.node && list_mem[i].block == key.block
                    && list_mem[i].member == key.member)
                hit = i;
        end
        case (cmd)
            CMD_APPEND: begin
                lim = (cap_limit < DEPTH) ? int'(cap_limit) : DEPTH;
                if (list_len >= lim) begin
                    res.status = ST_FULL;
                end else begin
                    list_mem[list_len] = key;
                    list_len++;
                end
            end
            CMD_FIND: begin
                if (hit < 0) res.status = ST_MISS;
                else res.slot = hit[5:0];
            end
            CMD_REM_KEY: begin
                if (hit < 0) begin
                    res.status = ST_MISS;
                end else begin
                    res.slot = hit[5:0];
                    for (int i = hit; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            CMD_REM_NODE: begin
                wr = 0;
                for (int i = 0; i < list_len; i++) begin
                    if (list_mem[i].node != key.node) begin
                        list_mem[wr] = list_mem[i];
                        wr++;
                    end
                end
                list_len = wr;
            end
            CMD_SHIFT: begin
                for (int i = 0; i < list_len; i++) begin
                    if (list_mem[i].pidx >= ref_idx)
                        list_mem[i].pidx = list_mem[i].pidx + delta;
                end
            end
            CMD_READ: begin
                if (pos >= list_len) res.status = ST_RANGE;
                else res.entry = list_mem[pos];
            end
            default: ;
        endcase
        res.count = list_len[6:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            list_len    = 0;
            cap_limit   = 7'd64;
            o_err_count = 0;
            result_q.delete();
        end else begin
            if (i_cfg_wr_en)
                cap_limit = i_cfg_wr_data;
            if (i_rsp_valid && i_rsp_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("result transaction with nothing expected",
                                    16'(i_rsp_status), 16'd0);
                end else begin
                    want = result_q.pop_front();
                    if (i_rsp_status != want.status)
                        report_mismatch("status", 16'(i_rsp_status), 16'(want.status));
                    if (i_rsp_data[5:0] != want.slot)
                        report_mismatch("found_slot", 16'(i_rsp_data[5:0]), 16'(want.slot));
                    if (i_rsp_data[13:6] != want.entry.node)
                        report_mismatch("node_out", 16'(i_rsp_data[13:6]),
                                        16'(want.entry.node));
                    if (i_rsp_data[21:14] != want.entry.block)
                        report_mismatch("block_out", 16'(i_rsp_data[21:14]),
                                        16'(want.entry.block));
                    if (i_rsp_data[29:22] != want.entry.member)
                        report_mismatch("member_out", 16'(i_rsp_data[29:22]),
                                        16'(want.entry.member));
                    if (i_rsp_data[45:30] != want.entry.pidx)
                        report_mismatch("packet_index_out", i_rsp_data[45:30],
                                        want.entry.pidx);
                    if (i_rsp_data[52:46] != want.count)
                        report_mismatch("entry_count", 16'(i_rsp_data[52:46]),
                                        16'(want.count));
                end
            end
            if (i_cmd_valid && i_cmd_ready)
                result_q.push_back(apply_command(t_cmd'(i_cmd_kind), i_cmd_data));
        end
        o_pending = result_q.size();
    end

endmodule

>>> tb/tb_keyed_compacting_entry_list_core.sv
`timescale 1ns / 100ps

module tb_keyed_compacting_entry_list_core;
    import kcel_pkg::*;

    localparam int   LIST_DEPTH  = 64;
    localparam int   QUIET_LIMIT = 3000;
    localparam t_cmd CMD_SPARE   = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [6:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int          err_count;
    int          pending;
    bit          steady;
    int unsigned rx_taken;
    int unsigned quiet_cycles = 0;

    keyed_compacting_entry_list_core #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    kcel_list_checker #(
        .DEPTH(LIST_DEPTH)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_valid   (s_axis_tvalid),
        .i_cmd_ready   (s_axis_tready),
        .i_cmd_data    (s_axis_tdata),
        .i_cmd_kind    (s_axis_tuser),
        .i_rsp_valid   (m_axis_tvalid),
        .i_rsp_ready   (m_axis_tready),
        .i_rsp_data    (m_axis_tdata),
        .i_rsp_status  (m_axis_tuser),
        .o_err_count   (err_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    // result side: random stalls, one long hold-off once the list has had time to fill
    initial begin
        int unsigned gap;
        bit          held_off;
        m_axis_tready = 1'b0;
        rx_taken      = 0;
        held_off      = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held_off && rx_taken >= 300) begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            gap = steady ? 0 : pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            if (m_axis_tvalid)
                rx_taken++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_cmd(input t_cmd cmd, input logic [7:0] node, input logic [7:0] blk,
                            input logic [7:0] member, input logic [15:0] pidx,
                            input logic [15:0] ref_idx, input logic [7:0] shamt,
                            input logic [7:0] pos);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {pos, shamt, ref_idx, pidx, member, blk, node};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random(input bit fill_bias);
        int unsigned pick;
        t_cmd        cmd;
        logic [7:0]  node;
        logic [7:0]  blk;
        logic [7:0]  member;
        logic [7:0]  pos;
        logic [15:0] pidx;
        logic [15:0] ref_idx;
        pick = $urandom_range(0, 99);
        if (fill_bias && pick < 60) begin
            cmd = CMD_APPEND;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 30)      cmd = CMD_APPEND;
            else if (pick < 43) cmd = CMD_FIND;
            else if (pick < 56) cmd = CMD_REM_KEY;
            else if (pick < 61) cmd = CMD_REM_NODE;
            else if (pick < 71) cmd = CMD_SHIFT;
            else if (pick < 88) cmd = CMD_READ;
            else if (pick < 96) cmd = CMD_COUNT;
            else                cmd = CMD_SPARE;
        end
        // small key pool so that finds and removals hit often
        node   = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        blk    = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        member = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 1)) : 8'($urandom);
        pidx   = ($urandom_range(0, 99) < 10) ? 16'hFFF0 + 16'($urandom_range(0, 15))
                                              : 16'($urandom);
        pick   = $urandom_range(0, 99);
        if (pick < 15)      ref_idx = 16'h0000;
        else if (pick < 25) ref_idx = 16'hFFFF;
        else                ref_idx = 16'($urandom);
        pos = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, 66)) : 8'($urandom);
        send_cmd(cmd, node, blk, member, pidx, ref_idx, 8'($urandom), pos);
    endtask

    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [6:0] cap, input int items, input int fill_items,
                             input bit no_gaps);
        quiesce();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cap;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        steady = no_gaps;
        for (int k = 0; k < items; k++)
            send_random(k < fill_items);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_APPEND;
        steady        = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, extremes, wraps, adjacent removals
        run_phase(7'd64, 0, 0, 1'b0);
        send_cmd(CMD_COUNT,    8'd0,   8'd0,   8'd0,   16'h0000, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_READ,     8'd0,   8'd0,   8'd0,   16'h0000, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_FIND,     8'd1,   8'd2,   8'd3,   16'h0000, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_REM_KEY,  8'd1,   8'd2,   8'd3,   16'h0000, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_REM_NODE, 8'd1,   8'd0,   8'd0,   16'h0000, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_SHIFT,    8'd0,   8'd0,   8'd0,   16'h0000, 16'h0000, 8'h7F, 8'd0);
        send_cmd(CMD_SPARE,    8'hFF,  8'hFF,  8'hFF,  16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_cmd(CMD_APPEND,   8'd0,   8'd0,   8'd0,   16'h0000, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_APPEND,   8'hFF,  8'hFF,  8'hFF,  16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_cmd(CMD_APPEND,   8'd1,   8'd2,   8'd3,   16'h7FFF, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_APPEND,   8'd1,   8'd2,   8'd3,   16'h8000, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_APPEND,   8'd1,   8'd9,   8'd9,   16'h0010, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_FIND,     8'd1,   8'd2,   8'd3,   16'h0000, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_SHIFT,    8'd0,   8'd0,   8'd0,   16'h0000, 16'h8000, 8'h7F, 8'd0);
        send_cmd(CMD_SHIFT,    8'd0,   8'd0,   8'd0,   16'h0000, 16'h0000, 8'h80, 8'd0);
        send_cmd(CMD_READ,     8'd0,   8'd0,   8'd0,   16'h0000, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_READ,     8'd0,   8'd0,   8'd0,   16'h0000, 16'h0000, 8'h00, 8'd4);
        send_cmd(CMD_READ,     8'd0,   8'd0,   8'd0,   16'h0000, 16'h0000, 8'h00, 8'd5);
        send_cmd(CMD_READ,     8'd0,   8'd0,   8'd0,   16'h0000, 16'h0000, 8'h00, 8'hFF);
        send_cmd(CMD_REM_KEY,  8'd1,   8'd2,   8'd3,   16'h0000, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_REM_NODE, 8'd1,   8'd0,   8'd0,   16'h0000, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_COUNT,    8'd0,   8'd0,   8'd0,   16'h0000, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_REM_KEY,  8'd0,   8'd0,   8'd0,   16'h0000, 16'h0000, 8'h00, 8'd0);
        send_cmd(CMD_READ,     8'd0,   8'd0,   8'd0,   16'h0000, 16'h0000, 8'h00, 8'd0);

        run_phase(7'd64, 420, 110, 1'b0);
        run_phase(7'd0,  60,  20,  1'b0);
        run_phase(7'd1,  150, 0,   1'b1);
        run_phase(7'd5,  200, 0,   1'b0);
        run_phase(7'd37, 250, 60,  1'b0);
        run_phase(7'd64, 330, 40,  1'b1);

        quiesce();
        repeat (LIST_DEPTH + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
